// File: sv/lpht_pkg.sv
// Shared types and constants of the linear-probing hash table.
// Used by the home slot unit, the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

  localparam int KEY_W    = 31;
  localparam int VALUE_W  = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 10;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] found_value;
    logic [SLOT_W-1:0]         slot;
  } rsp_t;

  // One table entry as held in the memory.
  typedef struct packed {
    logic                      used;
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                capture;
    logic                slot_clr;
    logic                hash_start;
    logic                slot_home;
    logic                rd_en;
    logic                step;
    logic                wr_clear;
    logic                wr_insert;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    logic                res_slot;
    logic                res_value;
    logic                out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              hash_done;
    logic              used;
    logic              key_match;
    logic              probe_last;
    logic              sweep_last;
    logic              out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: sv/lpht_stream_if.sv
// Valid/ready stream interface carrying one payload of type T.
// Used with the request and response types of lpht_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lpht_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/lpht_mod.sv
// Home slot unit: key modulo the table depth.
// A mask for a power-of-two depth, otherwise a two-stage reciprocal multiplication.
`timescale 1ns / 1ps
`default_nettype none

module lpht_mod #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [lpht_pkg::KEY_W-1:0]  key_i,
  output logic                             done_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]   rem_o
);

  localparam int  IDX_W = $clog2(TABLE_DEPTH);
  localparam int  R_W   = IDX_W + 1;
  localparam bit  POW2  = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

  generate
    if (POW2) begin : g_mask
      assign done_o = start_i;
      assign rem_o  = key_i[IDX_W-1:0];
    end else begin : g_recip
      localparam int               PROD_W     = lpht_pkg::KEY_W + 32;
      localparam int               SHIFT      = lpht_pkg::KEY_W + IDX_W;
      localparam logic [63:0]      RECIP_FULL = (64'd1 << SHIFT) / 64'(TABLE_DEPTH);
      localparam logic [31:0]      RECIP      = RECIP_FULL[31:0];
      localparam logic [R_W-1:0]   DIV        = R_W'(TABLE_DEPTH);

      logic                       v1_q;
      logic                       v2_q;
      logic [PROD_W-1:0]          prod_q;
      logic [lpht_pkg::KEY_W-1:0] key1_q;
      logic [PROD_W-1:0]          qd;
      logic [PROD_W-1:0]          diff;
      logic [R_W-1:0]             diff_q;
      logic [R_W-1:0]             rem_full;

      // The scaled reciprocal is rounded down, so the quotient estimate is the
      // true quotient or one below it; one conditional subtraction finishes.
      assign qd       = PROD_W'(prod_q[PROD_W-1:SHIFT]) * PROD_W'(TABLE_DEPTH);
      assign diff     = PROD_W'(key1_q) - qd;
      assign rem_full = (diff_q >= DIV) ? (diff_q - DIV) : diff_q;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v1_q <= 1'b0;
          v2_q <= 1'b0;
        end else begin
          v1_q <= start_i;
          v2_q <= v1_q;
        end
      end

      always_ff @(posedge clk_i) begin
        if (start_i) begin
          prod_q <= PROD_W'(key_i) * PROD_W'(RECIP);
          key1_q <= key_i;
        end
        if (v1_q) begin
          diff_q <= diff[R_W-1:0];
        end
      end

      assign done_o = v2_q;
      assign rem_o  = rem_full[IDX_W-1:0];
    end
  endgenerate

`ifndef ASSERT_OFF
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rem_o < TABLE_DEPTH))
    else $error("home slot beyond the table depth");
`endif

endmodule

`default_nettype wire

// File: sv/lpht_ctrl.sv
// Controller of the hash table: sequences init, clear, hashing and probing.
// Depends on lpht_pkg for the command and status structs and the codes.
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  output logic                 req_ready_o,
  input  wire lpht_pkg::stat_t stat_i,
  output lpht_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_HASH,
    S_HWAIT,
    S_READ,
    S_EVAL
  } state_e;

  state_e state_q, state_d;
  logic   result_q, result_d;

  assign req_ready_o = (state_q == S_IDLE) && !result_q;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    result_d = result_q;

    // A finished result moves to the output register as soon as it is free.
    if (result_q && stat_i.out_free) begin
      cmd_o.out_load = 1'b1;
      result_d       = 1'b0;
    end

    case (state_q)
      S_INIT: begin
        cmd_o.wr_clear = 1'b1;
        cmd_o.step     = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i && !result_q) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.func)
          lpht_pkg::FUNC_CLEAR: begin
            cmd_o.slot_clr = 1'b1;
            state_d        = S_CLEAR;
          end
          lpht_pkg::FUNC_INSERT,
          lpht_pkg::FUNC_LOOKUP: begin
            state_d = S_HASH;
          end
          default: begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = lpht_pkg::STATUS_OK;
            result_d         = 1'b1;
            state_d          = S_IDLE;
          end
        endcase
      end
      S_CLEAR: begin
        cmd_o.wr_clear = 1'b1;
        cmd_o.step     = 1'b1;
        if (stat_i.sweep_last) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = lpht_pkg::STATUS_OK;
          result_d         = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_HASH: begin
        cmd_o.hash_start = 1'b1;
        if (stat_i.hash_done) begin
          cmd_o.slot_home = 1'b1;
          state_d         = S_READ;
        end else begin
          state_d = S_HWAIT;
        end
      end
      S_HWAIT: begin
        if (stat_i.hash_done) begin
          cmd_o.slot_home = 1'b1;
          state_d         = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EVAL;
      end
      S_EVAL: begin
        if (stat_i.func == lpht_pkg::FUNC_INSERT) begin
          if (!stat_i.used) begin
            cmd_o.wr_insert  = 1'b1;
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = lpht_pkg::STATUS_OK;
            cmd_o.res_slot   = 1'b1;
          end else if (stat_i.probe_last) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = lpht_pkg::STATUS_FULL;
          end else begin
            cmd_o.step = 1'b1;
          end
        end else begin
          if (!stat_i.used) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = lpht_pkg::STATUS_MISS;
          end else if (stat_i.key_match) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = lpht_pkg::STATUS_OK;
            cmd_o.res_slot   = 1'b1;
            cmd_o.res_value  = 1'b1;
          end else if (stat_i.probe_last) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = lpht_pkg::STATUS_MISS;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
        if (cmd_o.res_load) begin
          result_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      result_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      result_q <= result_d;
    end
  end

`ifndef ASSERT_OFF
  a_eval_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> $past(state_q == S_READ))
    else $error("entry evaluated without a fresh memory read");
`endif

endmodule

`default_nettype wire

// File: sv/lpht_dp.sv
// Datapath of the hash table: request registers, entry memory, probe
// counters, result and output registers. Uses lpht_pkg and lpht_mod.
`timescale 1ns / 1ps
`default_nettype none

module lpht_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lpht_pkg::req_t  req_data_i,
  input  wire lpht_pkg::cmd_t  cmd_i,
  output lpht_pkg::stat_t      stat_o,
  input  wire logic            rsp_ready_i,
  output logic                 rsp_valid_o,
  output lpht_pkg::rsp_t       rsp_data_o
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_DEPTH - 1);

  lpht_pkg::entry_t mem [TABLE_DEPTH];
  lpht_pkg::entry_t rd_q;
  lpht_pkg::entry_t wdata;

  logic [lpht_pkg::FUNC_W-1:0]         func_q;
  logic [lpht_pkg::KEY_W-1:0]          key_q;
  logic signed [lpht_pkg::VALUE_W-1:0] value_q;
  logic [IDX_W-1:0]                    slot_q;
  logic [IDX_W-1:0]                    slot_next;
  logic [IDX_W-1:0]                    cnt_q;
  logic [IDX_W-1:0]                    home;
  logic                                hash_done;
  logic                                wr_en;

  logic [lpht_pkg::STATUS_W-1:0]       res_status_q;
  logic signed [lpht_pkg::VALUE_W-1:0] res_value_q;
  logic [IDX_W-1:0]                    res_slot_q;
  logic [IDX_W+lpht_pkg::SLOT_W-1:0]   slot_ext;
  logic                                out_valid_q;
  lpht_pkg::rsp_t                      out_q;
  logic                                out_free;

  lpht_mod #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.hash_start),
    .key_i   (key_q),
    .done_o  (hash_done),
    .rem_o   (home)
  );

  assign slot_next = (slot_q == LAST) ? '0 : slot_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= req_data_i.func;
      key_q   <= req_data_i.key;
      value_q <= req_data_i.value;
    end
  end

  // The slot register also serves as the address of the clearing sweep,
  // so it starts at zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.slot_clr) begin
      slot_q <= '0;
    end else if (cmd_i.slot_home) begin
      slot_q <= home;
      cnt_q  <= '0;
    end else if (cmd_i.step) begin
      slot_q <= slot_next;
      cnt_q  <= cnt_q + 1'b1;
    end
  end

  assign wr_en = cmd_i.wr_clear || cmd_i.wr_insert;

  always_comb begin
    wdata = '0;
    if (cmd_i.wr_insert) begin
      wdata.used  = 1'b1;
      wdata.key   = key_q;
      wdata.value = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[slot_q] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_value_q  <= cmd_i.res_value ? rd_q.value : '0;
      res_slot_q   <= cmd_i.res_slot ? slot_q : '0;
    end
  end

  // Slot numbers are reported in ten bits, whatever the depth.
  assign slot_ext = {{lpht_pkg::SLOT_W{1'b0}}, res_slot_q};
  assign out_free = !out_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.status      <= res_status_q;
      out_q.found_value <= res_value_q;
      out_q.slot        <= slot_ext[lpht_pkg::SLOT_W-1:0];
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_data_o  = out_q;

  always_comb begin
    stat_o            = '0;
    stat_o.func       = func_q;
    stat_o.hash_done  = hash_done;
    stat_o.used       = rd_q.used;
    stat_o.key_match  = (rd_q.key == key_q);
    stat_o.probe_last = (cnt_q == LAST);
    stat_o.sweep_last = (slot_q == LAST);
    stat_o.out_free   = out_free;
  end

`ifndef ASSERT_OFF
  a_insert_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_insert |-> !rd_q.used)
    else $error("insert overwrites an occupied entry");

  a_out_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result loaded over one not yet taken");
`endif

endmodule

`default_nettype wire

// File: sv/linear_probe_hash_table.sv
// Top level of the linear-probing hash table: controller and datapath.
// Depends on lpht_pkg, lpht_stream_if, lpht_ctrl and lpht_dp.
//
//   channel  direction  payload                      transaction
//   req_i    in         func, key, value             valid && ready
//   rsp_o    out        status, found_value, slot    valid && ready
//
// Clear runs from acceptance through decode and a sweep over every slot to a
// valid result; insert and lookup run through decode, the home slot
// calculation (a mask for a power-of-two depth, a reciprocal multiplication
// otherwise) and one memory read and one evaluation per slot probed.
// After reset a clearing pass over every slot runs before any request is taken.
// The result waits in an output register; the next request is taken while it
// waits, and its own result is held back until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  lpht_stream_if.sink    req_i,
  lpht_stream_if.source  rsp_o
);

  lpht_pkg::cmd_t  cmd;
  lpht_pkg::stat_t stat;
  lpht_pkg::rsp_t  rsp_data;
  logic            rsp_valid;
  logic            req_ready;

  lpht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lpht_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_data_i  (req_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_data_o  (rsp_data)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;
  assign rsp_o.data  = rsp_data;

endmodule

`default_nettype wire
